@@ design/printable_run_extractor_macros.svh @@
// assertion macros for the printable run extractor
// used by the modules that carry assertions; needs nothing else
`ifndef PRINTABLE_RUN_EXTRACTOR_MACROS_SVH
`define PRINTABLE_RUN_EXTRACTOR_MACROS_SVH

// condition implies consequence in the same cycle
`define PRE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("printable run extractor: same-cycle check failed");

// condition implies consequence in the next cycle
`define PRE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("printable run extractor: next-cycle check failed");

`endif

@@ design/pre_pkg.sv @@
// shared types, constants and helpers of the printable run extractor
// used by the result interface, the controller, the datapath and the top level
package pre_pkg;

    localparam int MAX_MIN_LENGTH = 16;
    localparam int OFFSET_BITS    = 32;
    localparam int RUN_OFFSET_W   = 32;
    localparam int LEN_W          = 5;
    localparam int IDX_W          = $clog2(MAX_MIN_LENGTH);
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 5;

    localparam logic [LEN_W-1:0] MIN_LENGTH_RESET = LEN_W'(4);

    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_TILDE   = 8'h7E;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_LENGTH  = 1'b0,
        REG_SHOW_OFFSET = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic take;
        logic emit;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic printable;
        logic reported;
        logic fill_done;
        logic emit_last;
        logic out_free;
    } status_t;

    function automatic logic is_printable(input logic [7:0] b);
        return b inside {[CHAR_SPACE:CHAR_TILDE], CHAR_TAB};
    endfunction

endpackage

@@ design/pre_item_if.sv @@
// input channel of the printable run extractor: one byte or end of file
// depends on pre_pkg for nothing but shares its naming
interface pre_item_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_file;

    modport source (output valid, output data_byte, output end_of_file, input ready);
    modport sink (input valid, input data_byte, input end_of_file, output ready);
endinterface

@@ design/pre_result_if.sv @@
// output channel of the printable run extractor: one emitted character
// depends on pre_pkg for the offset width
interface pre_result_if;
    logic                             valid;
    logic                             ready;
    logic [7:0]                       out_byte;
    logic                             run_start;
    logic [pre_pkg::RUN_OFFSET_W-1:0] run_offset;
    logic                             offset_valid;
    logic                             last;

    modport source (output valid, output out_byte, output run_start, output run_offset,
                    output offset_valid, output last, input ready);
    modport sink (input valid, input out_byte, input run_start, input run_offset,
                  input offset_valid, input last, output ready);
endinterface

@@ design/pre_datapath.sv @@
// datapath: config registers, run buffer, run counter, byte offset, output register
// depends on pre_pkg; driven by pre_ctrl through cmd_t and status_t
module pre_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [pre_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pre_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [7:0]                       data_byte,
    input  logic                             end_of_file,
    input  logic                             out_ready,
    input  pre_pkg::cmd_t                    cmd,
    output pre_pkg::status_t                 status,
    output logic                             out_valid,
    output logic [7:0]                       out_byte,
    output logic                             run_start,
    output logic [pre_pkg::RUN_OFFSET_W-1:0] run_offset,
    output logic                             offset_valid,
    output logic                             last
);

    logic [pre_pkg::LEN_W-1:0]        min_length_reg;
    logic                             show_offset_reg;
    logic [pre_pkg::LEN_W-1:0]        run_count_reg, run_count_next;
    logic [pre_pkg::OFFSET_BITS-1:0]  byte_offset_reg, byte_offset_next;
    logic [pre_pkg::OFFSET_BITS-1:0]  start_reg;
    logic [pre_pkg::IDX_W-1:0]        idx_reg;
    logic [7:0]                       buffer_reg [pre_pkg::MAX_MIN_LENGTH];
    logic                             out_valid_reg, out_valid_next;
    logic [7:0]                       out_byte_reg;
    logic                             run_start_reg;
    logic [pre_pkg::RUN_OFFSET_W-1:0] run_offset_reg;
    logic                             offset_valid_reg;
    logic                             last_reg;

    logic [pre_pkg::LEN_W-1:0] eff_len;
    logic [pre_pkg::LEN_W-1:0] len_m1;
    logic                      printable;
    logic                      reported;
    logic                      fill_done;
    logic                      emit_last;
    logic                      out_free;
    logic                      load_take;

    // out-of-range lengths clamp to 1..MAX_MIN_LENGTH
    always_comb
    begin
        if (min_length_reg == '0)
            eff_len = pre_pkg::LEN_W'(1);
        else if (min_length_reg > pre_pkg::LEN_W'(pre_pkg::MAX_MIN_LENGTH))
            eff_len = pre_pkg::LEN_W'(pre_pkg::MAX_MIN_LENGTH);
        else
            eff_len = min_length_reg;
    end

    assign len_m1    = eff_len - pre_pkg::LEN_W'(1);
    assign printable = !end_of_file && pre_pkg::is_printable(data_byte);
    assign reported  = run_count_reg >= eff_len;
    assign fill_done = (run_count_reg + pre_pkg::LEN_W'(1)) == eff_len;
    assign emit_last = {1'b0, idx_reg} == len_m1;
    assign out_free  = !out_valid_reg || out_ready;
    assign load_take = cmd.take && reported;

    assign status.printable = printable;
    assign status.reported  = reported;
    assign status.fill_done = fill_done;
    assign status.emit_last = emit_last;
    assign status.out_free  = out_free;

    always_comb
    begin
        run_count_next   = run_count_reg;
        byte_offset_next = byte_offset_reg;
        if (cmd.take)
        begin
            if (printable)
            begin
                if (!reported)
                    run_count_next = run_count_reg + pre_pkg::LEN_W'(1);
            end
            else
                run_count_next = '0;
            if (end_of_file)
                byte_offset_next = '0;
            else
                byte_offset_next = byte_offset_reg + pre_pkg::OFFSET_BITS'(1);
        end
        if (load_take || cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_length_reg  <= pre_pkg::MIN_LENGTH_RESET;
            show_offset_reg <= 1'b0;
            run_count_reg   <= '0;
            byte_offset_reg <= '0;
            idx_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    pre_pkg::REG_MIN_LENGTH:  min_length_reg  <= cfg_data;
                    pre_pkg::REG_SHOW_OFFSET: show_offset_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            run_count_reg   <= run_count_next;
            byte_offset_reg <= byte_offset_next;
            out_valid_reg   <= out_valid_next;
            if (cmd.take)
                idx_reg <= '0;
            else if (cmd.emit)
                idx_reg <= idx_reg + pre_pkg::IDX_W'(1);
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            start_reg <= byte_offset_reg - pre_pkg::OFFSET_BITS'(len_m1);
            // run count is below the clamped length here, so it fits the index
            if (printable && !reported)
                buffer_reg[run_count_reg[pre_pkg::IDX_W-1:0]] <= data_byte;
        end
        if (load_take)
        begin
            out_byte_reg     <= printable ? data_byte : pre_pkg::CHAR_NEWLINE;
            run_start_reg    <= 1'b0;
            run_offset_reg   <= '0;
            offset_valid_reg <= 1'b0;
            last_reg         <= 1'b1;
        end
        else if (cmd.emit)
        begin
            out_byte_reg     <= buffer_reg[idx_reg];
            run_start_reg    <= idx_reg == '0;
            run_offset_reg   <= (idx_reg == '0) ? start_reg[pre_pkg::RUN_OFFSET_W-1:0] : '0;
            offset_valid_reg <= (idx_reg == '0) && show_offset_reg;
            last_reg         <= emit_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign run_start    = run_start_reg;
    assign run_offset   = run_offset_reg;
    assign offset_valid = offset_valid_reg;
    assign last         = last_reg;

endmodule

@@ design/pre_ctrl.sv @@
// controller: accepts items and sequences the burst that replays the run buffer
// depends on pre_pkg and the assertion macros header
`include "printable_run_extractor_macros.svh"

module pre_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  pre_pkg::status_t status,
    output pre_pkg::cmd_t    cmd
);

    pre_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= pre_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd.take   = 1'b0;
        cmd.emit   = 1'b0;
        case (state_reg)
            pre_pkg::ST_IDLE:
            begin
                in_ready = status.out_free;
                if (in_valid && status.out_free)
                begin
                    cmd.take = 1'b1;
                    // run just reached the threshold: replay the buffer
                    if (status.printable && !status.reported && status.fill_done)
                        state_next = pre_pkg::ST_EMIT;
                end
            end
            pre_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.emit_last)
                        state_next = pre_pkg::ST_IDLE;
                end
            end
            default:
                state_next = pre_pkg::ST_IDLE;
        endcase
    end

    `PRE_ASSERT_SAME(a_no_take_in_burst, clk, rst_n, state_reg == pre_pkg::ST_EMIT, !in_ready && !cmd.take)
    `PRE_ASSERT_NEXT(a_fill_starts_burst, clk, rst_n, cmd.take && status.printable && !status.reported && status.fill_done, state_reg == pre_pkg::ST_EMIT)
    `PRE_ASSERT_NEXT(a_burst_ends, clk, rst_n, cmd.emit && status.emit_last, state_reg == pre_pkg::ST_IDLE)
    `PRE_ASSERT_SAME(a_one_command, clk, rst_n, 1'b1, !(cmd.take && cmd.emit))

endmodule

@@ design/printable_run_extractor.sv @@
// printable run extractor: reports runs of printable bytes of at least min_length.
// item channel (sink): one data_byte per transaction, or end_of_file to close the stream.
// result channel (source): emitted characters; last marks the final result of an item.
// config port: cfg_we with cfg_index 0 = min_length, 1 = show_offset; write only when idle.
// a byte or newline result is in the output register in the cycle after its item
// is taken; a replayed run starts only once the controller is in the burst.
// one item per cycle while no burst is running and no result waits; an item that brings
// a run to min_length (clamped) triggers a replay of the run buffer, min_length results
// at one a cycle while the receiver takes them, so ready stays low until the last
// replayed result is issued (the buffer is read one entry per result).
// when the receiver stalls, the output register holds its result and the item
// channel drops ready until the result has left; a new item is taken in the same
// cycle that the waiting result is taken.
// reset (rst_n low, asynchronous): run count and byte offset clear, min_length
// returns to 4 and show_offset to 0, no result is pending.
// depends on pre_pkg, pre_item_if, pre_result_if, pre_ctrl and pre_datapath
module printable_run_extractor (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [pre_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pre_pkg::CFG_DATA_W-1:0] cfg_data,
    pre_item_if.sink                       item,
    pre_result_if.source                   result
);

    pre_pkg::cmd_t    cmd;
    pre_pkg::status_t status;

    pre_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (item.ready),
        .status   (status),
        .cmd      (cmd)
    );

    pre_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .data_byte    (item.data_byte),
        .end_of_file  (item.end_of_file),
        .out_ready    (result.ready),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (result.valid),
        .out_byte     (result.out_byte),
        .run_start    (result.run_start),
        .run_offset   (result.run_offset),
        .offset_valid (result.offset_valid),
        .last         (result.last)
    );

endmodule
